[hdl/mec_pkg.sv]
// Shared constants and types for the Morse element classifier.
package mec_pkg;

    // Field widths of the request and result items
    localparam int FUNC_WIDTH     = 2;
    localparam int TS_WIDTH       = 16;
    localparam int ELEMENT_WIDTH  = 3;
    localparam int MODE_WIDTH     = 3;
    localparam int DOT_WIDTH      = 16;
    localparam int TIME_WIDTH_DEF = 16;
    localparam int M_TDATA_WIDTH  = 24;

    // Request kinds carried on tuser
    localparam logic [FUNC_WIDTH-1:0] FUNC_RISE  = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_FALL  = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_RECAL = 2'd2;

    // Element codes
    localparam logic [ELEMENT_WIDTH-1:0] EL_NONE      = 3'd0;
    localparam logic [ELEMENT_WIDTH-1:0] EL_DOT       = 3'd1;
    localparam logic [ELEMENT_WIDTH-1:0] EL_DASH      = 3'd2;
    localparam logic [ELEMENT_WIDTH-1:0] EL_BAD_PULSE = 3'd3;
    localparam logic [ELEMENT_WIDTH-1:0] EL_END_CHAR  = 3'd4;
    localparam logic [ELEMENT_WIDTH-1:0] EL_END_WORD  = 3'd5;
    localparam logic [ELEMENT_WIDTH-1:0] EL_BAD_SPACE = 3'd6;

    // Mode codes reported with each result
    localparam logic [MODE_WIDTH-1:0] MODE_CAL_RISE  = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_CAL_FALL  = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_SYNC_RISE = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SYNC_FALL = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_DEC_RISE  = 3'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_DEC_FALL  = 3'd5;

    // One result item
    typedef struct packed {
        logic [DOT_WIDTH-1:0]     dot_length;
        logic [MODE_WIDTH-1:0]    mode;
        logic                     calibrated;
        logic [ELEMENT_WIDTH-1:0] element;
    } mec_result_t;

endpackage

[hdl/mec_core.sv]
// Calibration and timing classification state machine of the Morse classifier.
module mec_core
    import mec_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [FUNC_WIDTH-1:0] func,
    input  logic [TIME_WIDTH-1:0] ts,
    output mec_result_t           result
);

    localparam int EW = TIME_WIDTH + 3;
    localparam int CW = TIME_WIDTH + 14;

    typedef enum logic [MODE_WIDTH-1:0] {
        PH_CAL_RISE  = MODE_CAL_RISE,
        PH_CAL_FALL  = MODE_CAL_FALL,
        PH_SYNC_RISE = MODE_SYNC_RISE,
        PH_SYNC_FALL = MODE_SYNC_FALL,
        PH_DEC_RISE  = MODE_DEC_RISE,
        PH_DEC_FALL  = MODE_DEC_FALL
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]   rise_time_reg, rise_time_next;
    logic [TIME_WIDTH-1:0]   fall_time_reg, fall_time_next;
    logic [TIME_WIDTH-1:0]   dot_ticks_reg, dot_ticks_next;
    logic [TIME_WIDTH-1:0]   first_width_reg, first_width_next;

    logic [TIME_WIDTH-1:0]   pulse_w, space_w;
    logic [EW-1:0]           pulse_x, space_x;
    logic [EW-1:0]           lo1, hi1, lo3, hi3, lo7, hi7;
    logic [ELEMENT_WIDTH-1:0] space_cls, pulse_cls;
    logic [CW-1:0]           s_scaled, f_scaled;
    logic [EW-1:0]           s_triple;
    logic                    first_is_dot, second_is_dot;
    logic [ELEMENT_WIDTH-1:0] element;
    logic                    calibrated;

    function automatic logic in_band(input logic [EW-1:0] w, input logic [EW-1:0] lo,
                                     input logic [EW-1:0] hi);
        in_band = (w >= lo) && (w <= hi);
    endfunction

    // Wrapped widths ending at the new edge
    assign pulse_w = ts - rise_time_reg;
    assign space_w = ts - fall_time_reg;
    assign pulse_x = EW'(pulse_w);
    assign space_x = EW'(space_w);

    // Bands around one, three and seven dot lengths
    assign lo1 = EW'(dot_ticks_reg);
    assign hi1 = lo1 + EW'(1);
    assign lo3 = (lo1 << 1) + lo1;
    assign hi3 = lo3 + EW'(3);
    assign lo7 = (lo1 << 3) - lo1;
    assign hi7 = lo7 + EW'(7);

    // Classify the space before a rising edge and the pulse before a falling edge
    always_comb begin
        if (in_band(space_x, lo1, hi1)) begin
            space_cls = EL_NONE;
        end else if (in_band(space_x, lo3, hi3)) begin
            space_cls = EL_END_CHAR;
        end else if (in_band(space_x, lo7, hi7)) begin
            space_cls = EL_END_WORD;
        end else begin
            space_cls = EL_BAD_SPACE;
        end
        if (in_band(pulse_x, lo1, hi1)) begin
            pulse_cls = EL_DOT;
        end else if (in_band(pulse_x, lo3, hi3)) begin
            pulse_cls = EL_DASH;
        end else begin
            pulse_cls = EL_BAD_PULSE;
        end
    end

    // Compare the new pulse with the stored one: under a third, or over three times
    assign s_scaled      = CW'(pulse_w) * CW'(3333);
    assign f_scaled      = CW'(first_width_reg) * CW'(10000);
    assign first_is_dot  = s_scaled >= f_scaled;
    assign s_triple      = (pulse_x << 1) + pulse_x;
    assign second_is_dot = s_triple < EW'(first_width_reg);

    // Next state
    always_comb begin
        phase_next       = phase_reg;
        rise_time_next   = rise_time_reg;
        fall_time_next   = fall_time_reg;
        dot_ticks_next   = dot_ticks_reg;
        first_width_next = first_width_reg;
        element          = EL_NONE;
        calibrated       = 1'b0;
        unique case (phase_reg)
            PH_CAL_RISE: begin
                if (func == FUNC_RISE) begin
                    rise_time_next = ts;
                    phase_next     = PH_CAL_FALL;
                end
            end
            PH_CAL_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_time_next = ts;
                    phase_next     = PH_CAL_RISE;
                    if (first_width_reg == '0) begin
                        first_width_next = pulse_w;
                    end else if (first_is_dot) begin
                        dot_ticks_next = first_width_reg;
                        calibrated     = 1'b1;
                        phase_next     = PH_SYNC_RISE;
                    end else if (second_is_dot) begin
                        dot_ticks_next = pulse_w;
                        calibrated     = 1'b1;
                        phase_next     = PH_SYNC_RISE;
                    end else begin
                        first_width_next = pulse_w;
                    end
                end
            end
            PH_SYNC_RISE, PH_DEC_RISE: begin
                if (func == FUNC_RISE) begin
                    rise_time_next = ts;
                    element        = space_cls;
                    if (space_cls == EL_END_CHAR || phase_reg == PH_DEC_RISE) begin
                        phase_next = PH_DEC_FALL;
                    end else begin
                        phase_next = PH_SYNC_FALL;
                    end
                end else if (func == FUNC_RECAL) begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            PH_SYNC_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_time_next = ts;
                    phase_next     = PH_SYNC_RISE;
                end else if (func == FUNC_RECAL) begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            PH_DEC_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_time_next = ts;
                    phase_next     = PH_DEC_RISE;
                    element        = pulse_cls;
                end else if (func == FUNC_RECAL) begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            default: begin
                phase_next = PH_CAL_RISE;
            end
        endcase
    end

    // Advance the state on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_CAL_RISE;
            rise_time_reg   <= '0;
            fall_time_reg   <= '0;
            dot_ticks_reg   <= '0;
            first_width_reg <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            rise_time_reg   <= rise_time_next;
            fall_time_reg   <= fall_time_next;
            dot_ticks_reg   <= dot_ticks_next;
            first_width_reg <= first_width_next;
        end
    end

    assign result.element    = element;
    assign result.calibrated = calibrated;
    assign result.mode       = phase_next;
    assign result.dot_length = DOT_WIDTH'(dot_ticks_next);

endmodule

[hdl/morse_element_classifier.sv]
// Top level of the Morse element classifier: stream ports and pipeline registers.
//
// Takes one timestamped edge or recalibrate request per cycle and returns exactly
// one result per request. Throughput is one request per clock unless the result
// side stalls. Requests pass the input register ahead of the classifier state
// machine and the result register behind it. The dot length is learned from two
// pulse widths and then pulses and spaces are graded against one, three and seven
// dot lengths. Widths are differences of TIME_WIDTH-bit wrapping timestamps.
module morse_element_classifier
    import mec_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TS_WIDTH-1:0]      s_axis_tdata,  // [15:0] timestamp
    input  logic [FUNC_WIDTH-1:0]    s_axis_tuser,  // [1:0] func
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [2:0] element, [3] calibrated, [6:4] mode, [22:7] dot_length, [23] zero
    output logic [M_TDATA_WIDTH-1:0] m_axis_tdata
);

    logic                  in_valid_reg;
    logic [FUNC_WIDTH-1:0] func_reg;
    logic [TS_WIDTH-1:0]   ts_reg;
    logic                  out_valid_reg;
    mec_result_t           out_result_reg;
    mec_result_t           core_result;
    logic                  advance;

    // Move the held request into the result register when it has room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mec_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (advance),
        .func   (func_reg),
        .ts     (TIME_WIDTH'(ts_reg)),
        .result (core_result)
    );

    // Hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            func_reg <= s_axis_tuser;
            ts_reg   <= s_axis_tdata;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg.dot_length, out_result_reg.mode,
                            out_result_reg.calibrated, out_result_reg.element};

`ifndef SYNTH
    // Completed calibration always lands in sync, waiting for a rise
    a_cal_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.calibrated) |->
            out_result_reg.mode == MODE_SYNC_RISE)
        else $error("calibration did not move to sync rise");

    // A graded pulse leaves the machine decoding, waiting for a rise
    a_pulse_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_result_reg.element == EL_DOT ||
                           out_result_reg.element == EL_DASH ||
                           out_result_reg.element == EL_BAD_PULSE)) |->
            out_result_reg.mode == MODE_DEC_RISE)
        else $error("pulse element outside decode");

    // End of character always leads into decode, waiting for a fall
    a_eoc_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.element == EL_END_CHAR) |->
            out_result_reg.mode == MODE_DEC_FALL)
        else $error("end of character did not enter decode");

    // A stalled result with a held request blocks new requests
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while pipeline full");

    // A downstream ready never stalls the input side
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with result side ready");
`endif

endmodule

[tb/sv/tb_morse_element_classifier.sv]
// Self-checking stream testbench for the Morse element classifier.
`timescale 1ns / 1ps

module tb_morse_element_classifier;
    import mec_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_REQS  = 1624;
    localparam int LONG_HOLD    = 300;
    localparam int N_DIRECTED   = 26;

    // Request kind that the block must ignore
    localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;

    // One row of the directed table; known_ok marks a hand-written result
    typedef struct packed {
        logic [FUNC_WIDTH-1:0] func;
        logic [TS_WIDTH-1:0]   ts;
        logic                  known_ok;
        mec_result_t           known;
    } stim_row_t;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [TS_WIDTH-1:0]      s_axis_tdata  = '0;  // [15:0] timestamp
    logic [FUNC_WIDTH-1:0]    s_axis_tuser  = '0;  // [1:0] func
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [2:0] element, [3] calibrated, [6:4] mode, [22:7] dot_length, [23] zero
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    // Predicted line state
    logic [MODE_WIDTH-1:0] line_phase  = MODE_CAL_RISE;
    logic [TS_WIDTH-1:0]   rise_ts     = '0;
    logic [TS_WIDTH-1:0]   fall_ts     = '0;
    logic [DOT_WIDTH-1:0]  dot_len     = '0;
    logic [TS_WIDTH-1:0]   first_pulse = '0;

    mec_result_t pending_results[$];
    stim_row_t   directed_rows[N_DIRECTED];

    int          error_count     = 0;
    int          cycle_count     = 0;
    bit          gaps_on         = 1'b1;
    int          hold_off_cycles = 0;
    int unsigned cal_len         = 10;

    morse_element_classifier uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // True when width w lies in [dot*mult, (dot+1)*mult], compared at 64 bits
    function automatic bit fits_band(input logic [TS_WIDTH-1:0] w, input int unsigned mult);
        longint unsigned w64;
        longint unsigned d64;
        w64 = w;
        d64 = dot_len;
        return (w64 >= d64 * mult) && (w64 <= (d64 + 1) * mult);
    endfunction

    // Advance the predicted state by one request and return the expected result
    function automatic mec_result_t classify_edge(input logic [FUNC_WIDTH-1:0] func,
                                                  input logic [TS_WIDTH-1:0] ts);
        mec_result_t     res;
        logic [TS_WIDTH-1:0] width;
        longint unsigned w64;
        longint unsigned f64;
        res = '0;
        case (line_phase)
            MODE_CAL_RISE: begin
                if (func == FUNC_RISE) begin
                    rise_ts    = ts;
                    line_phase = MODE_CAL_FALL;
                end
            end
            MODE_CAL_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_ts    = ts;
                    line_phase = MODE_CAL_RISE;
                    width      = fall_ts - rise_ts;
                    w64        = width;
                    f64        = first_pulse;
                    // A zero stored width means no first pulse yet
                    if (first_pulse == '0) begin
                        first_pulse = width;
                    end else if (w64 * 3333 >= f64 * 10000) begin
                        dot_len        = first_pulse;
                        res.calibrated = 1'b1;
                    end else if (w64 * 3 < f64) begin
                        dot_len        = width;
                        res.calibrated = 1'b1;
                    end else begin
                        first_pulse = width;
                    end
                    if (res.calibrated)
                        line_phase = MODE_SYNC_RISE;
                end
            end
            MODE_SYNC_RISE, MODE_DEC_RISE: begin
                if (func == FUNC_RISE) begin
                    rise_ts = ts;
                    width   = rise_ts - fall_ts;
                    if (fits_band(width, 1))
                        res.element = EL_NONE;
                    else if (fits_band(width, 3))
                        res.element = EL_END_CHAR;
                    else if (fits_band(width, 7))
                        res.element = EL_END_WORD;
                    else
                        res.element = EL_BAD_SPACE;
                    // End of character drops straight into decoding
                    if (res.element == EL_END_CHAR || line_phase == MODE_DEC_RISE)
                        line_phase = MODE_DEC_FALL;
                    else
                        line_phase = MODE_SYNC_FALL;
                end else if (func == FUNC_RECAL) begin
                    line_phase  = MODE_CAL_RISE;
                    first_pulse = '0;
                end
            end
            MODE_SYNC_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_ts    = ts;
                    line_phase = MODE_SYNC_RISE;
                end else if (func == FUNC_RECAL) begin
                    line_phase  = MODE_CAL_RISE;
                    first_pulse = '0;
                end
            end
            MODE_DEC_FALL: begin
                if (func == FUNC_FALL) begin
                    fall_ts    = ts;
                    line_phase = MODE_DEC_RISE;
                    width      = fall_ts - rise_ts;
                    if (fits_band(width, 1))
                        res.element = EL_DOT;
                    else if (fits_band(width, 3))
                        res.element = EL_DASH;
                    else
                        res.element = EL_BAD_PULSE;
                end else if (func == FUNC_RECAL) begin
                    line_phase  = MODE_CAL_RISE;
                    first_pulse = '0;
                end
            end
            default: begin
                line_phase = MODE_CAL_RISE;
            end
        endcase
        res.mode       = line_phase;
        res.dot_length = dot_len;
        return res;
    endfunction

    // Build one directed row
    function automatic stim_row_t stim(input logic [FUNC_WIDTH-1:0] func,
                                       input logic [TS_WIDTH-1:0] ts,
                                       input logic known_ok,
                                       input logic [ELEMENT_WIDTH-1:0] element,
                                       input logic cal,
                                       input logic [MODE_WIDTH-1:0] mode,
                                       input logic [DOT_WIDTH-1:0] dot);
        stim_row_t r;
        r.func             = func;
        r.ts               = ts;
        r.known_ok         = known_ok;
        r.known.element    = element;
        r.known.calibrated = cal;
        r.known.mode       = mode;
        r.known.dot_length = dot;
        return r;
    endfunction

    // Width near a band of the current dot length, including just outside it
    function automatic logic [TS_WIDTH-1:0] band_width(input int unsigned mult);
        longint unsigned d64;
        longint unsigned low_edge;
        d64      = dot_len;
        low_edge = d64 * mult;
        case ($urandom_range(0, 9))
            0:       return TS_WIDTH'(low_edge - 1);
            1:       return TS_WIDTH'(low_edge + mult + 1);
            default: return TS_WIDTH'(low_edge + $urandom_range(0, mult));
        endcase
    endfunction

    // Width anywhere, mostly within a few dot lengths
    function automatic logic [TS_WIDTH-1:0] loose_width();
        if ($urandom_range(0, 3) == 0)
            return TS_WIDTH'($urandom_range(0, 65535));
        return TS_WIDTH'($urandom_range(0, 8 * dot_len + 8));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Compare one result with the oldest expectation
    task automatic check_result(input logic [M_TDATA_WIDTH-1:0] data);
        mec_result_t got;
        mec_result_t want;
        got = data[$bits(mec_result_t)-1:0];
        if (pending_results.size() == 0) begin
            report_mismatch("result with no request pending", data, 0);
        end else begin
            want = pending_results.pop_front();
            if (got.element !== want.element)
                report_mismatch("element", got.element, want.element);
            if (got.calibrated !== want.calibrated)
                report_mismatch("calibrated", got.calibrated, want.calibrated);
            if (got.mode !== want.mode)
                report_mismatch("mode", got.mode, want.mode);
            if (got.dot_length !== want.dot_length)
                report_mismatch("dot_length", got.dot_length, want.dot_length);
            if (data[M_TDATA_WIDTH-1] !== 1'b0)
                report_mismatch("pad bit", data[M_TDATA_WIDTH-1], 0);
        end
    endtask

    // Offer one request after a random gap and record its expected result
    task automatic send_request(input logic [FUNC_WIDTH-1:0] func,
                                input logic [TS_WIDTH-1:0] ts,
                                input logic known_ok, input mec_result_t known);
        int          gap;
        mec_result_t predicted;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        s_axis_tuser  <= func;
        do @(posedge aclk); while (!s_axis_tready);
        predicted = classify_edge(func, ts);
        pending_results.push_back(known_ok ? known : predicted);
    endtask

    // Pick a request that keeps the line mostly well formed for the current phase
    task automatic send_random_request();
        logic [FUNC_WIDTH-1:0] func;
        logic [TS_WIDTH-1:0]   width;
        logic [TS_WIDTH-1:0]   ts;
        int                    pick;
        pick  = $urandom_range(0, 99);
        width = '0;
        if (pick < 6) begin
            // Noise: any kind, any time
            func = FUNC_WIDTH'($urandom_range(0, 3));
            ts   = TS_WIDTH'($urandom_range(0, 65535));
        end else if (pick < 8 && line_phase >= MODE_SYNC_RISE) begin
            // Start a new session with a fresh dot length and idling style
            func    = FUNC_RECAL;
            ts      = TS_WIDTH'($urandom_range(0, 65535));
            cal_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 65535)
                                                  : $urandom_range(1, 40);
            gaps_on = ($urandom_range(0, 3) != 0);
        end else begin
            case (line_phase)
                MODE_CAL_RISE: begin
                    func  = FUNC_RISE;
                    width = TS_WIDTH'($urandom_range(1, 8 * cal_len));
                end
                MODE_CAL_FALL: begin
                    func = FUNC_FALL;
                    if ($urandom_range(0, 9) == 0)
                        width = loose_width();
                    else if ($urandom_range(0, 1) == 0)
                        width = TS_WIDTH'(cal_len);
                    else
                        width = TS_WIDTH'(3 * cal_len + $urandom_range(1, 3));
                end
                MODE_SYNC_RISE, MODE_DEC_RISE: begin
                    func = FUNC_RISE;
                    case ($urandom_range(0, 4))
                        0:       width = band_width(1);
                        1:       width = band_width(3);
                        2:       width = band_width(7);
                        3:       width = loose_width();
                        default: width = band_width(1);
                    endcase
                end
                default: begin
                    func = FUNC_FALL;
                    case ($urandom_range(0, 4))
                        0, 1:    width = band_width(1);
                        2, 3:    width = band_width(3);
                        default: width = loose_width();
                    endcase
                end
            endcase
            ts = (func == FUNC_RISE) ? fall_ts + width : rise_ts + width;
        end
        send_request(func, ts, 1'b0, '0);
    endtask

    // Directed table: hand-written results only where they are obvious
    initial begin
        // Wrong edge, unused kind and recalibrate while calibrating are ignored
        directed_rows[0]  = stim(FUNC_FALL,   16'h0000, 1'b1, EL_NONE, 1'b0, MODE_CAL_RISE, 16'd0);
        directed_rows[1]  = stim(FUNC_UNUSED, 16'hFFFF, 1'b1, EL_NONE, 1'b0, MODE_CAL_RISE, 16'd0);
        directed_rows[2]  = stim(FUNC_RECAL,  16'h0000, 1'b1, EL_NONE, 1'b0, MODE_CAL_RISE, 16'd0);
        directed_rows[3]  = stim(FUNC_RISE,   16'hFFFF, 1'b1, EL_NONE, 1'b0, MODE_CAL_FALL, 16'd0);
        // Zero first width: the next pulse is again taken as the first
        directed_rows[4]  = stim(FUNC_FALL,   16'hFFFF, 1'b1, EL_NONE, 1'b0, MODE_CAL_RISE, 16'd0);
        // Dash of 31 then dot of 10 calibrates to 10
        directed_rows[5]  = stim(FUNC_RISE,   16'h0010, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[6]  = stim(FUNC_FALL,   16'h002F, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[7]  = stim(FUNC_RISE,   16'h0050, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[8]  = stim(FUNC_FALL,   16'h005A, 1'b0, '0, 1'b0, '0, '0);
        // Sync: dot space goes to sync fall, fall returns, end of char starts decode
        directed_rows[9]  = stim(FUNC_RISE,   16'h0065, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[10] = stim(FUNC_FALL,   16'h006F, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[11] = stim(FUNC_RISE,   16'h008D, 1'b0, '0, 1'b0, '0, '0);
        // Decode: dot, gap, dash, end of word, bad pulse, bad space, dot
        directed_rows[12] = stim(FUNC_FALL,   16'h0097, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[13] = stim(FUNC_RISE,   16'h00A2, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[14] = stim(FUNC_FALL,   16'h00C3, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[15] = stim(FUNC_RISE,   16'h0110, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[16] = stim(FUNC_FALL,   16'h011C, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[17] = stim(FUNC_RISE,   16'h0130, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[18] = stim(FUNC_FALL,   16'h013B, 1'b0, '0, 1'b0, '0, '0);
        // Wrong edge in decode, then recalibrate
        directed_rows[19] = stim(FUNC_FALL,   16'h0200, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[20] = stim(FUNC_RECAL,  16'h0000, 1'b0, '0, 1'b0, '0, '0);
        // Pulse across the timestamp wrap, then a zero second width
        directed_rows[21] = stim(FUNC_RISE,   16'hFFF0, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[22] = stim(FUNC_FALL,   16'h0004, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[23] = stim(FUNC_RISE,   16'h1000, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[24] = stim(FUNC_FALL,   16'h1000, 1'b0, '0, 1'b0, '0, '0);
        directed_rows[25] = stim(FUNC_RISE,   16'h1002, 1'b0, '0, 1'b0, '0, '0);
    end

    // Check every result taken by the receiver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
    end

    // Receiver: random stalls per result, one long hold-off when asked
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 16) : 0;
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("morse_element_classifier test failed");
        $finish;
    end

    // Main sequence: reset, directed table, random sessions, drain
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].ts,
                         directed_rows[i].known_ok, directed_rows[i].known);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            // Hold the receiver off once so the block fills and stalls requests
            if (i == RANDOM_REQS / 2)
                hold_off_cycles = LONG_HOLD;
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("morse_element_classifier test passed");
        else
            $display("morse_element_classifier test failed");
        $finish;
    end

endmodule
